@@ src/bmp_stream_unpacker_top_defines.svh @@
// ----------------------------------------------------------------------------
// BMP stream unpacker assertion macros
// Shared property wrappers; they expect clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef BMP_STREAM_UNPACKER_TOP_DEFINES_SVH
`define BMP_STREAM_UNPACKER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define BSU_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define BSU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/bsu_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// BMP stream unpacker package
// Types, header layout constants and result codes shared by all modules.
// ----------------------------------------------------------------------------
package bsu_pkg;

  // Header layout
  localparam int HDR_LEN  = 54;  // file header plus info header
  localparam int HDR_KEEP = 34;  // bytes that the checks look at
  localparam int IDX_W    = $clog2(HDR_KEEP);
  localparam int POS_W    = 31;  // positive signed 32-bit offset range

  localparam int OFS_TYPE   = 0;
  localparam int OFS_OFFSET = 10;
  localparam int OFS_INFO   = 14;
  localparam int OFS_WIDTH  = 18;
  localparam int OFS_HEIGHT = 22;
  localparam int OFS_PLANES = 26;
  localparam int OFS_BPP    = 28;
  localparam int OFS_COMPR  = 30;

  localparam logic [15:0] BMP_MAGIC    = 16'h4d42;
  localparam logic [31:0] INFO_SIZE    = 32'd40;
  localparam logic [15:0] BPP_24       = 16'd24;
  localparam logic [15:0] BPP_32       = 16'd32;
  localparam logic [7:0]  ALPHA_OPAQUE = 8'hff;

  localparam int MAX_DIMENSION_DEF = 8192;
  localparam int FIFO_DEPTH        = 4;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_SKIP,
    PH_PIXELS,
    PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    K_PIXEL  = 3'd0,
    K_ACCEPT = 3'd1,
    K_REJECT = 3'd2,
    K_OFFSET = 3'd3,
    K_TRUNC  = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        last_pixel;
    logic [13:0] image_width;
    logic [13:0] image_height;
  } result_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [7:0]       data;
  } hdr_wr_t;

  typedef struct packed {
    logic             ok;          // header passes every format check
    logic             off_bad;     // pixel offset negative or inside header
    logic             off_at_hdr;  // pixels follow the header directly
    logic [POS_W-1:0] off;
    logic             alpha;       // 32 bpp
    logic [13:0]      img_w;
    logic [13:0]      img_h;
  } hdr_info_t;

  typedef struct packed {
    logic first;
    logic second;
  } push_t;

endpackage
`default_nettype wire

@@ src/bsu_header.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// BMP header store and checker
// Holds the checked header bytes and registers the format decision and size.
// ----------------------------------------------------------------------------
module bsu_header import bsu_pkg::*; #(
  parameter  int MAX_DIMENSION = MAX_DIMENSION_DEF,
  localparam int DIM_W         = $clog2(MAX_DIMENSION + 1),
  localparam int PROD_W        = 2 * DIM_W
) (
  input  wire logic              clk,
  input  wire hdr_wr_t           wr,
  output hdr_info_t              info,
  output logic [PROD_W-1:0]      product
);

  logic [7:0] hdr [HDR_KEEP];
  logic [15:0] f_type, f_planes, f_bpp;
  logic [31:0] f_off, f_info, f_w, f_h, f_compr;
  logic        w_ok, h_ok;
  hdr_info_t   info_next;

  // Store header bytes as they arrive
  always_ff @(posedge clk) begin
    if (wr.en) begin
      hdr[wr.idx] <= wr.data;
    end
  end

  // Little-endian fields
  assign f_type   = {hdr[OFS_TYPE+1], hdr[OFS_TYPE]};
  assign f_off    = {hdr[OFS_OFFSET+3], hdr[OFS_OFFSET+2], hdr[OFS_OFFSET+1], hdr[OFS_OFFSET]};
  assign f_info   = {hdr[OFS_INFO+3], hdr[OFS_INFO+2], hdr[OFS_INFO+1], hdr[OFS_INFO]};
  assign f_w      = {hdr[OFS_WIDTH+3], hdr[OFS_WIDTH+2], hdr[OFS_WIDTH+1], hdr[OFS_WIDTH]};
  assign f_h      = {hdr[OFS_HEIGHT+3], hdr[OFS_HEIGHT+2], hdr[OFS_HEIGHT+1], hdr[OFS_HEIGHT]};
  assign f_planes = {hdr[OFS_PLANES+1], hdr[OFS_PLANES]};
  assign f_bpp    = {hdr[OFS_BPP+1], hdr[OFS_BPP]};
  assign f_compr  = {hdr[OFS_COMPR+3], hdr[OFS_COMPR+2], hdr[OFS_COMPR+1], hdr[OFS_COMPR]};

  assign w_ok = (f_w != 32'd0) && (f_w <= 32'(MAX_DIMENSION));
  assign h_ok = (f_h != 32'd0) && (f_h <= 32'(MAX_DIMENSION));

  // Evaluate the checks from the stored bytes
  always_comb begin
    info_next.ok         = (f_type == BMP_MAGIC) && (f_info == INFO_SIZE) && w_ok && h_ok &&
                           (f_planes == 16'd1) && ((f_bpp == BPP_24) || (f_bpp == BPP_32)) &&
                           (f_compr == 32'd0);
    info_next.off_bad    = f_off[31] || (f_off < 32'(HDR_LEN));
    info_next.off_at_hdr = (f_off == 32'(HDR_LEN));
    info_next.off        = f_off[POS_W-1:0];
    info_next.alpha      = (f_bpp == BPP_32);
    info_next.img_w      = f_w[13:0];
    info_next.img_h      = f_h[13:0];
  end

  // Register the decision and the pixel count; both settle long before byte 53
  always_ff @(posedge clk) begin
    info    <= info_next;
    product <= PROD_W'(f_w[DIM_W-1:0]) * PROD_W'(f_h[DIM_W-1:0]);
  end

endmodule
`default_nettype wire

@@ src/bsu_parser.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// BMP stream parser
// Input word register, phase sequencer and pixel assembly; emits up to two
// results per byte.
// ----------------------------------------------------------------------------
`include "bmp_stream_unpacker_top_defines.svh"
module bsu_parser import bsu_pkg::*; #(
  parameter  int MAX_DIMENSION = MAX_DIMENSION_DEF,
  localparam int DIM_W         = $clog2(MAX_DIMENSION + 1),
  localparam int PROD_W        = 2 * DIM_W
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [7:0]        s_tdata,   // data_byte
  input  wire logic              s_tuser,   // start_of_buffer
  input  wire logic              s_tlast,   // end_of_buffer
  input  wire logic              room,
  input  wire hdr_info_t         info,
  input  wire logic [PROD_W-1:0] product,
  output hdr_wr_t                hdr_wr,
  output push_t                  push,
  output result_t                res0,
  output result_t                res1
);

  // Input word register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_start, in_end;
  logic       proceed;

  // Parse state
  phase_t            phase, phase_next;
  logic [POS_W-1:0]  pos, pos_next;
  logic [1:0]        comp, comp_next;
  logic [23:0]       partial, partial_next;
  logic              has_alpha, has_alpha_next;
  logic [PROD_W-1:0] pixels_left, pixels_left_next;

  // Pixel pushes watched by the checks below
  logic              pix_push, last_push;

  assign proceed  = in_valid && room;
  assign s_tready = !in_valid || room;

  // Hold the accepted word until the result queue has room for two results
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (proceed) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte  <= s_tdata;
      in_start <= s_tuser;
      in_end   <= s_tlast;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      pos         <= '0;
      comp        <= '0;
      partial     <= '0;
      has_alpha   <= 1'b0;
      pixels_left <= '0;
    end else begin
      phase       <= phase_next;
      pos         <= pos_next;
      comp        <= comp_next;
      partial     <= partial_next;
      has_alpha   <= has_alpha_next;
      pixels_left <= pixels_left_next;
    end
  end

  // Next state and results
  always_comb begin
    phase_t            ph;
    logic [POS_W-1:0]  p;
    logic [1:0]        c;
    logic [23:0]       pp;
    logic              a;
    logic [PROD_W-1:0] lft;
    logic [23:0]       pp_new;
    logic [2:0]        c_new;
    logic              emit;
    logic              end_chk;

    phase_next       = phase;
    pos_next         = pos;
    comp_next        = comp;
    partial_next     = partial;
    has_alpha_next   = has_alpha;
    pixels_left_next = pixels_left;
    hdr_wr           = '0;
    push             = '0;
    res0             = '0;
    res1             = '0;
    ph               = phase;
    p                = pos;
    c                = comp;
    pp               = partial;
    a                = has_alpha;
    lft              = pixels_left;
    pp_new           = partial;
    c_new            = {1'b0, comp};
    emit             = 1'b0;
    end_chk          = 1'b0;

    if (proceed) begin
      // A start word restarts the parser on this byte
      if (in_start) begin
        ph  = PH_HEADER;
        p   = '0;
        c   = '0;
        pp  = '0;
        a   = 1'b0;
        lft = '0;
      end
      phase_next       = ph;
      pos_next         = p;
      comp_next        = c;
      partial_next     = pp;
      has_alpha_next   = a;
      pixels_left_next = lft;

      case (ph)
        PH_HEADER: begin
          hdr_wr.en   = (p < POS_W'(HDR_KEEP));
          hdr_wr.idx  = p[IDX_W-1:0];
          hdr_wr.data = in_byte;
          pos_next    = p + POS_W'(1);
          if (p == POS_W'(HDR_LEN - 1)) begin
            push.first = 1'b1;
            if (!info.ok) begin
              res0.kind  = K_REJECT;
              phase_next = PH_DONE;
            end else begin
              res0.kind         = K_ACCEPT;
              res0.image_width  = info.img_w;
              res0.image_height = info.img_h;
              has_alpha_next    = info.alpha;
              pixels_left_next  = product;
              comp_next         = '0;
              if (info.off_bad) begin
                push.second = 1'b1;
                res1.kind   = K_OFFSET;
                phase_next  = PH_DONE;
              end else begin
                phase_next = info.off_at_hdr ? PH_PIXELS : PH_SKIP;
                end_chk    = 1'b1;
              end
            end
          end else begin
            end_chk = 1'b1;
          end
        end
        PH_SKIP: begin
          pos_next = p + POS_W'(1);
          if (pos_next >= info.off) begin
            phase_next = PH_PIXELS;
          end
          end_chk = 1'b1;
        end
        PH_PIXELS: begin
          // Shift in r, g, b; a fourth byte is alpha
          if (c != 2'd3) begin
            pp_new = {pp[15:0], in_byte};
            c_new  = {1'b0, c} + 3'd1;
          end else begin
            c_new = 3'd4;
          end
          emit = ((c_new == 3'd3) && !a) || (c_new == 3'd4);
          if (emit) begin
            push.first      = 1'b1;
            res0.kind       = K_PIXEL;
            res0.red        = pp_new[23:16];
            res0.green      = pp_new[15:8];
            res0.blue       = pp_new[7:0];
            res0.alpha      = a ? in_byte : ALPHA_OPAQUE;
            res0.last_pixel = (lft <= PROD_W'(1));
            comp_next       = '0;
            partial_next    = '0;
            pixels_left_next = (lft == '0) ? lft : lft - PROD_W'(1);
            if (lft <= PROD_W'(1)) begin
              phase_next = PH_DONE;
            end else begin
              end_chk = 1'b1;
            end
          end else begin
            comp_next    = c_new[1:0];
            partial_next = pp_new;
            end_chk      = 1'b1;
          end
        end
        default: begin
          // idle or done: drop the byte
        end
      endcase

      // Early end of buffer follows any result of the same byte
      if (end_chk && in_end) begin
        phase_next = PH_DONE;
        if (push.first) begin
          push.second = 1'b1;
          res1.kind   = K_TRUNC;
        end else begin
          push.first = 1'b1;
          res0.kind  = K_TRUNC;
        end
      end
    end
  end

  assign pix_push  = push.first && (res0.kind == K_PIXEL);
  assign last_push = pix_push && res0.last_pixel;

  `BSU_ASSERT_IMPL(a_pixel_phase, pix_push, phase == PH_PIXELS, "pixel outside pixel phase")
  `BSU_ASSERT_NEXT(a_last_done, last_push, phase == PH_DONE, "last pixel did not end image")
  `BSU_ASSERT_IMPL(a_hdr_pos, phase == PH_HEADER, pos < POS_W'(HDR_LEN), "position past header")

endmodule
`default_nettype wire

@@ src/bsu_result_fifo.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// BMP result queue
// Small queue taking up to two results a cycle and giving one to the master.
// ----------------------------------------------------------------------------
`include "bmp_stream_unpacker_top_defines.svh"
module bsu_result_fifo import bsu_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire push_t   push,
  input  wire result_t d0,
  input  wire result_t d1,
  output logic         room,
  output logic         m_tvalid,
  input  wire logic    m_tready,
  output result_t      head
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  result_t            mem [FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count, count_next;
  logic               pop;

  assign pop      = m_tvalid && m_tready;
  assign m_tvalid = (count != '0);
  assign room     = (count <= CNT_W'(FIFO_DEPTH - 2));
  assign head     = mem[rd_ptr];

  assign count_next = count + CNT_W'(push.first) + CNT_W'(push.second) - CNT_W'(pop);

  // Write entries
  always_ff @(posedge clk) begin
    if (push.first) begin
      mem[wr_ptr] <= d0;
    end
    if (push.second) begin
      mem[wr_ptr + PTR_W'(1)] <= d1;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push.first) + PTR_W'(push.second);
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count_next;
    end
  end

  `BSU_ASSERT_IMPL(a_second_needs_first, push.second, push.first, "second push without first")
  `BSU_ASSERT_IMPL(a_no_overflow, push.first && push.second, room, "queue overflow on double push")
  `BSU_ASSERT_NEXT(a_pop_count, pop && !push.first, count == $past(count) - CNT_W'(1), "pop kept count")

endmodule
`default_nettype wire

@@ src/bmp_stream_unpacker_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// BMP stream unpacker
// Byte-serial decoder for uncompressed 24 and 32 bpp BMP images.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one file byte per word; tuser marks byte 0 of a new file
//   (it restarts the parser at any time) and tlast the final byte of the
//   buffer. m_axis carries one result per word: tuser is the kind (pixel,
//   header accepted, format rejected, offset negative or inside header,
//   truncated), tlast flags the final pixel, tdata holds the pixel bytes or
//   the parsed width and height.
//   Throughput is one byte per clock while the result queue has room. A
//   byte's results pass through the input word register and then the
//   four-entry result queue before m_axis. The last header byte and an early
//   end can give two results; the second leaves the queue after the first.
//   After reset the parser is idle and drops bytes until a start word.
//   When the receiver stalls, results collect in the queue; s_axis_tready
//   falls when a byte waits with under two entries free; no result is lost.
// ----------------------------------------------------------------------------
module bmp_stream_unpacker_top import bsu_pkg::*; #(
  parameter  int MAX_DIMENSION = MAX_DIMENSION_DEF,
  localparam int DIM_W         = $clog2(MAX_DIMENSION + 1),
  localparam int PROD_W        = 2 * DIM_W
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tuser,   // [0] start_of_buffer
  input  wire logic        s_axis_tlast,   // end_of_buffer
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,   // [7:0] red, [15:8] green, [23:16] blue,
                                           // [31:24] alpha, [45:32] image_width,
                                           // [59:46] image_height, [63:60] zero
  output logic [2:0]       m_axis_tuser,   // [2:0] kind
  output logic             m_axis_tlast    // last_pixel
);

  hdr_wr_t           hdr_wr;
  hdr_info_t         info;
  logic [PROD_W-1:0] product;
  push_t             push;
  result_t           res0, res1, head;
  logic              room;

  bsu_header #(.MAX_DIMENSION(MAX_DIMENSION)) u_header (
    .clk     (clk),
    .wr      (hdr_wr),
    .info    (info),
    .product (product)
  );

  bsu_parser #(.MAX_DIMENSION(MAX_DIMENSION)) u_parser (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_axis_tvalid),
    .s_tready (s_axis_tready),
    .s_tdata  (s_axis_tdata),
    .s_tuser  (s_axis_tuser),
    .s_tlast  (s_axis_tlast),
    .room     (room),
    .info     (info),
    .product  (product),
    .hdr_wr   (hdr_wr),
    .push     (push),
    .res0     (res0),
    .res1     (res1)
  );

  bsu_result_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .d0       (res0),
    .d1       (res1),
    .room     (room),
    .m_tvalid (m_axis_tvalid),
    .m_tready (m_axis_tready),
    .head     (head)
  );

  // Pack the head result onto the master side
  assign m_axis_tdata = {4'b0000, head.image_height, head.image_width,
                         head.alpha, head.blue, head.green, head.red};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last_pixel;

endmodule
`default_nettype wire
